// ===== src/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Holds request and status codes, cell operations and the controller states.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH     = 256;
    localparam int WORD_BITS = 32;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = $clog2(DEPTH);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [IDX_W-1:0]     idx_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_APPEND,
        CELL_TRIM
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_BACK
    } state_t;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        cell_op_t op;
        word_t    word;
        logic     full;
    } cell_ctrl_t;

endpackage

// ===== src/deq_req_if.sv =====
// Request channel of the double-ended queue: valid/ready plus request payload.
// Depends on deq_pkg for field widths.
`timescale 1ns / 1ps

interface deq_req_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::REQ_W-1:0]           req_type;
    logic signed [deq_pkg::DATA_W-1:0]   push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// ===== src/deq_rsp_if.sv =====
// Response channel of the double-ended queue: valid/ready plus result payload.
// Depends on deq_pkg for field widths.
`timescale 1ns / 1ps

interface deq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::STATUS_W-1:0]        status;
    logic signed [deq_pkg::DATA_W-1:0]   pop_value;
    logic [deq_pkg::CNT_W-1:0]           occupancy;
    logic                                is_empty;

    modport source (output valid, output status, output pop_value, output occupancy,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input pop_value, input occupancy,
                    input is_empty, output ready);
endinterface

// ===== src/deq_cell.sv =====
// One storage cell of the queue row: a word, a tail marker and a carry stage.
// Depends on deq_pkg for the cell operation codes and the control struct.
`timescale 1ns / 1ps

module deq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                home,
    input  deq_pkg::cell_ctrl_t ctrl,
    input  deq_pkg::word_t      lower_data,
    input  logic                lower_mark,
    input  deq_pkg::word_t      upper_data,
    input  logic                upper_mark,
    input  deq_pkg::word_t      upper_carry,
    output deq_pkg::word_t      data,
    output logic                mark,
    output deq_pkg::word_t      carry
);
    import deq_pkg::*;

    word_t data_reg, data_next;
    word_t carry_reg, carry_next;
    logic  mark_reg, mark_next;

    // The marker sits in the first free cell; the cell whose upper neighbor
    // carries it holds the back word.
    always_comb
    begin
        data_next  = data_reg;
        mark_next  = mark_reg;
        carry_next = upper_carry;
        case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_SHIFT_UP:
            begin
                data_next = lower_data;
                mark_next = lower_mark;
            end
            CELL_SHIFT_DOWN:
            begin
                data_next = upper_data;
                mark_next = upper_mark;
            end
            CELL_APPEND:
            begin
                if (mark_reg)
                begin
                    data_next = ctrl.word;
                end
                mark_next = lower_mark;
            end
            CELL_TRIM:
            begin
                if (upper_mark)
                begin
                    carry_next = data_reg;
                end
                mark_next = upper_mark;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= home;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        carry_reg <= carry_next;
    end

    assign data  = data_reg;
    assign mark  = mark_reg;
    assign carry = carry_reg;

endmodule

// ===== src/deq_ctrl.sv =====
// Request decoder, occupancy counter and response register of the queue.
// Depends on deq_pkg and on the deq_req_if and deq_rsp_if interfaces.
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    deq_req_if.sink             req,
    deq_rsp_if.source           rsp,
    input  deq_pkg::word_t      front_word,
    input  deq_pkg::word_t      back_word,
    output deq_pkg::cell_ctrl_t cell_ctrl
);
    import deq_pkg::*;

    state_t  state_reg, state_next;
    count_t  count_reg, count_next;
    idx_t    wait_reg, wait_next;
    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    word_t   pop_reg, pop_next;
    count_t  occ_reg, occ_next;
    logic    empty_reg, empty_next;

    logic      accept;
    logic      load;
    logic      is_full;
    logic      is_none;
    req_type_t kind;

    assign kind    = req_type_t'(req.req_type);
    assign is_full = (count_reg == CNT_W'(DEPTH));
    assign is_none = (count_reg == '0);
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        wait_next      = wait_reg;
        load           = 1'b0;
        status_next    = status_reg;
        pop_next       = pop_reg;
        cell_ctrl.op   = CELL_HOLD;
        cell_ctrl.word = req.push_value[WORD_BITS-1:0];
        cell_ctrl.full = is_full;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load        = 1'b1;
                    status_next = STATUS_DONE;
                    pop_next    = '0;
                    case (kind)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op = (kind == REQ_PUSH_FRONT) ? CELL_SHIFT_UP
                                                                        : CELL_APPEND;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (is_none)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                cell_ctrl.op = CELL_SHIFT_DOWN;
                                pop_next     = front_word;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (is_none)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // The back word walks down the carry chain.
                                load         = 1'b0;
                                cell_ctrl.op = CELL_TRIM;
                                count_next   = count_reg - 1'b1;
                                wait_next    = count_next[IDX_W-1:0];
                                state_next   = ST_BACK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BACK:
            begin
                if (wait_reg == '0)
                begin
                    load        = 1'b1;
                    status_next = STATUS_DONE;
                    pop_next    = back_word;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    wait_next = wait_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        occ_next   = load ? count_next : occ_reg;
        empty_next = load ? (count_next == '0) : empty_reg;
        if (!load)
        begin
            status_next = status_reg;
            pop_next    = pop_reg;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pop_reg    <= pop_next;
        occ_reg    <= occ_next;
        empty_reg  <= empty_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.pop_value = DATA_W'(pop_reg);
    assign rsp.occupancy = occ_reg;
    assign rsp.is_empty  = empty_reg;

endmodule

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, deq_cell and deq_ctrl.
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH signed words, built as a row of cells.
// Cell 0 always holds the front word; a one-hot tail marker travels along the
// row and sits in the first free cell. Every request returns one response with
// a status (done, pop refused because empty, push refused because full), the
// popped word (zero on pushes and refused pops), the occupancy after the
// request and an empty flag. Push front, push back, pop front and every
// refused request are answered directly: the response is registered in the
// cycle after the request is accepted, and a new request is taken every cycle
// as long as the response register is drained. A successful pop back waits
// while the back word moves toward cell 0 through the carry stages one cell
// per cycle; no request is accepted during that walk. The response register
// lets the next request in while a finished response still waits, as long as
// it is taken in the same cycle. The word storage needs no clearing after
// reset; only the tail marker and the control registers (state, occupancy and
// wait counters, response valid flag) are reset.
module double_ended_queue (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);
    import deq_pkg::*;

    cell_ctrl_t cell_ctrl;

    // Index DEPTH is the end of the row past the last cell.
    word_t cell_data  [DEPTH+1];
    logic  cell_mark  [DEPTH+1];
    word_t cell_carry [DEPTH+1];

    assign cell_data[DEPTH]  = '0;
    assign cell_mark[DEPTH]  = cell_ctrl.full;
    assign cell_carry[DEPTH] = '0;

    deq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .front_word (cell_data[0]),
        .back_word  (cell_carry[0]),
        .cell_ctrl  (cell_ctrl)
    );

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            word_t lo_data;
            logic  lo_mark;
            logic  is_home;

            // The bottom cell takes a pushed word and never receives the marker
            // from below; it holds the marker after reset.
            if (i == 0)
            begin : g_bottom
                assign lo_data = cell_ctrl.word;
                assign lo_mark = 1'b0;
                assign is_home = 1'b1;
            end
            else
            begin : g_inner
                assign lo_data = cell_data[i-1];
                assign lo_mark = cell_mark[i-1];
                assign is_home = 1'b0;
            end

            deq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .home        (is_home),
                .ctrl        (cell_ctrl),
                .lower_data  (lo_data),
                .lower_mark  (lo_mark),
                .upper_data  (cell_data[i+1]),
                .upper_mark  (cell_mark[i+1]),
                .upper_carry (cell_carry[i+1]),
                .data        (cell_data[i]),
                .mark        (cell_mark[i]),
                .carry       (cell_carry[i])
            );
        end
    endgenerate

endmodule
